// ===== src/overlay_fit_rect_calc_defines.svh =====
`ifndef OVERLAY_FIT_RECT_CALC_DEFINES_SVH
`define OVERLAY_FIT_RECT_CALC_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and quiet during reset.
`define OFRC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and quiet during reset.
`define OFRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ofrc_pkg.sv =====
`default_nettype none

package ofrc_pkg;

    localparam int DIM_BITS  = 13;
    localparam int PROD_BITS = 2 * DIM_BITS;
    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;

    typedef logic [DIM_BITS-1:0]  t_dim;
    typedef logic [PROD_BITS-1:0] t_prod;

    typedef enum logic [1:0] {
        MODE_RESIZE    = 2'd0,
        MODE_LETTERBOX = 2'd1,
        MODE_CROP      = 2'd2,
        MODE_ILLEGAL   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_ILLEGAL_MODE = 2'd1,
        STATUS_ZERO_DIM     = 2'd2
    } t_status;

    // Register index as seen in paddr bit 2.
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_CLEAR,
        KIND_ILLEGAL,
        KIND_ZERO,
        KIND_RESIZE,
        KIND_LETTERBOX,
        KIND_CROP
    } t_kind;

    typedef struct packed {
        t_dim canvas_width;
        t_dim canvas_height;
        t_dim overlay_width;
        t_dim overlay_height;
        logic overlay_present;
    } t_in_word;

    typedef struct packed {
        logic       erase_canvas;
        logic       draw_overlay;
        logic [1:0] status;
        t_dim       src_left;
        t_dim       src_top;
        t_dim       src_right;
        t_dim       src_bottom;
        t_dim       dst_left;
        t_dim       dst_top;
        t_dim       dst_right;
        t_dim       dst_bottom;
    } t_out_word;

    // Everything the last stage needs besides the quotient.
    typedef struct packed {
        t_kind kind;
        logic  vert;
        t_dim  base;
        t_dim  cw;
        t_dim  ch;
        t_dim  ow;
        t_dim  oh;
    } t_side;

    typedef struct packed {
        t_prod rem;
        t_dim  den;
        t_dim  quo;
        t_side side;
    } t_div_word;

endpackage

`default_nettype wire

// ===== src/ofrc_div_pipe.sv =====
`default_nettype none
`include "overlay_fit_rect_calc_defines.svh"

module ofrc_div_pipe
    import ofrc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_div_word i_in_word,
    output logic           o_in_take,
    output logic           o_out_valid,
    output t_div_word      o_out_word,
    input  wire logic      i_out_adv
);

    localparam int STAGES = DIM_BITS;

    logic [STAGES-1:0] r_v;
    t_div_word         r_w [STAGES];
    t_div_word         n_w [STAGES];
    logic [STAGES-1:0] w_en;

    // A stage loads when it is empty or its word moves on.
    always_comb begin
        w_en[STAGES-1] = !r_v[STAGES-1] || i_out_adv;
        for (int s = STAGES - 2; s >= 0; s--) begin
            w_en[s] = !r_v[s] || w_en[s+1];
        end
    end

    genvar gs;
    generate
        for (gs = 0; gs < STAGES; gs++) begin : g_stage
            localparam int K = STAGES - 1 - gs;
            t_div_word w_src;
            logic      w_src_v;
            t_prod     w_trial;

            if (gs == 0) begin : g_first
                assign w_src   = i_in_word;
                assign w_src_v = i_in_valid;
            end else begin : g_next
                assign w_src   = r_w[gs-1];
                assign w_src_v = r_v[gs-1];
            end

            assign w_trial = t_prod'(w_src.den) << K;

            // One restoring step: quotient bit K.
            always_comb begin
                n_w[gs] = w_src;
                if (w_src.rem >= w_trial) begin
                    n_w[gs].rem    = w_src.rem - w_trial;
                    n_w[gs].quo[K] = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[gs] <= 1'b0;
                end else if (w_en[gs]) begin
                    r_v[gs] <= w_src_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en[gs]) begin
                    r_w[gs] <= n_w[gs];
                end
            end
        end
    endgenerate

    assign o_in_take   = w_en[0];
    assign o_out_valid = r_v[STAGES-1];
    assign o_out_word  = r_w[STAGES-1];

    `OFRC_ASSERT_IMPL(a_div_rem_below_den, r_v[STAGES-1], r_w[STAGES-1].rem < t_prod'(r_w[STAGES-1].den), "division finished with remainder not below divisor")
    `OFRC_ASSERT_NEXT(a_div_out_held, r_v[STAGES-1] && !i_out_adv, r_v[STAGES-1] && $stable(r_w[STAGES-1]), "stalled quotient word lost or changed")
    `OFRC_ASSERT_IMPL(a_div_take_when_free, !o_in_take, r_v[0] && r_v[STAGES-1], "divider refused a word with room to spare")

endmodule

`default_nettype wire

// ===== src/overlay_fit_rect_calc.sv =====
// Overlay fit rectangle calculator.
// Input channel: i_in_valid / o_in_stall with the word i_in_word (canvas size,
// overlay size, overlay present). A word is taken at a clock edge where
// i_in_valid is high and o_in_stall is low.
// Output channel: o_out_valid / i_out_stall with o_out_word (erase and draw
// flags, status, source and destination rectangles), one result per input.
// The pipeline has one multiply stage, one compare and select stage, one
// restoring divider stage per quotient bit, and a final offset stage that
// doubles as the output register.
// Throughput is one word per cycle while the receiver does not stall; each
// stage holds one word.
// When the receiver stalls, the result holds on o_out_word and the stages
// behind it keep filling any empty slots; o_in_stall rises only once the
// whole pipeline is full.
// The APB port holds rendering_mode at 0x0 and clear_request at 0x4;
// pready is always high. Reset empties the pipeline, sets the mode to
// letterbox and clears the clear request.
`default_nettype none
`include "overlay_fit_rect_calc_defines.svh"

module overlay_fit_rect_calc
    import ofrc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_word             i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_word                 o_out_word,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0]      prdata,
    output logic                      pready
);

    typedef struct packed {
        t_in_word word;
        t_prod    p_oc;
        t_prod    p_co;
    } t_stage_a;

    t_mode     r_mode;
    logic      r_clear;

    logic      r_a_v;
    t_stage_a  r_a;
    t_stage_a  n_a;
    logic      r_b_v;
    t_div_word r_b;
    t_div_word n_b;
    logic      r_f_v;
    t_out_word r_f;
    t_out_word n_f;

    logic      w_a_en;
    logic      w_b_en;
    logic      w_f_en;
    logic      w_div_take;
    logic      w_div_v;
    t_div_word w_div;

    // Configuration registers.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_LETTERBOX;
            r_clear <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_MODE:  r_mode  <= t_mode'(pwdata[1:0]);
                REG_CLEAR: r_clear <= pwdata[0];
                default:   r_clear <= r_clear;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_MODE:  prdata[1:0] = r_mode;
            REG_CLEAR: prdata[0]   = r_clear;
            default:   prdata      = '0;
        endcase
    end

    // Stall chain, back to front.
    assign w_f_en     = !r_f_v || !i_out_stall;
    assign w_b_en     = !r_b_v || w_div_take;
    assign w_a_en     = !r_a_v || w_b_en;
    assign o_in_stall = !w_a_en;

    // Stage A: both cross products.
    always_comb begin
        n_a.word = i_in_word;
        n_a.p_oc = t_prod'(i_in_word.overlay_width) * t_prod'(i_in_word.canvas_height);
        n_a.p_co = t_prod'(i_in_word.canvas_width) * t_prod'(i_in_word.overlay_height);
    end

    // Stage B: classify and pick dividend, divisor and the span to center in.
    always_comb begin
        t_in_word w;
        logic     zero_dim;
        w        = r_a.word;
        zero_dim = (w.canvas_width == '0) || (w.canvas_height == '0) ||
                   (w.overlay_width == '0) || (w.overlay_height == '0);

        n_b           = '0;
        n_b.den       = t_dim'(1);
        n_b.side.cw   = w.canvas_width;
        n_b.side.ch   = w.canvas_height;
        n_b.side.ow   = w.overlay_width;
        n_b.side.oh   = w.overlay_height;
        n_b.side.kind = KIND_NONE;

        if (r_clear) begin
            n_b.side.kind = KIND_CLEAR;
        end else if (!w.overlay_present) begin
            n_b.side.kind = KIND_NONE;
        end else if (r_mode == MODE_ILLEGAL) begin
            n_b.side.kind = KIND_ILLEGAL;
        end else if (zero_dim) begin
            n_b.side.kind = KIND_ZERO;
        end else begin
            case (r_mode)
                MODE_RESIZE: begin
                    n_b.side.kind = KIND_RESIZE;
                end
                MODE_LETTERBOX: begin
                    n_b.side.kind = KIND_LETTERBOX;
                    if (r_a.p_oc > r_a.p_co) begin
                        // Overlay is wider: bars above and below.
                        n_b.rem       = r_a.p_co;
                        n_b.den       = w.overlay_width;
                        n_b.side.base = w.canvas_height;
                        n_b.side.vert = 1'b1;
                    end else begin
                        n_b.rem       = r_a.p_oc;
                        n_b.den       = w.overlay_height;
                        n_b.side.base = w.canvas_width;
                        n_b.side.vert = 1'b0;
                    end
                end
                MODE_CROP: begin
                    n_b.side.kind = KIND_CROP;
                    if (r_a.p_oc < r_a.p_co) begin
                        // Overlay is taller: trim top and bottom.
                        n_b.rem       = r_a.p_oc;
                        n_b.den       = w.canvas_width;
                        n_b.side.base = w.overlay_height;
                        n_b.side.vert = 1'b1;
                    end else begin
                        n_b.rem       = r_a.p_co;
                        n_b.den       = w.canvas_height;
                        n_b.side.base = w.overlay_width;
                        n_b.side.vert = 1'b0;
                    end
                end
                default: begin
                    n_b.side.kind = KIND_ILLEGAL;
                end
            endcase
        end
    end

    ofrc_div_pipe u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_b_v),
        .i_in_word   (r_b),
        .o_in_take   (w_div_take),
        .o_out_valid (w_div_v),
        .o_out_word  (w_div),
        .i_out_adv   (w_f_en)
    );

    // Final stage: center the scaled span and build the result word.
    always_comb begin
        t_side s;
        t_dim  diff;
        t_dim  off;
        t_dim  span_end;
        s        = w_div.side;
        diff     = s.base - w_div.quo;
        off      = diff >> 1;
        span_end = off + w_div.quo;

        n_f = '0;
        case (s.kind)
            KIND_CLEAR: begin
                n_f.erase_canvas = 1'b1;
            end
            KIND_ILLEGAL: begin
                n_f.status = STATUS_ILLEGAL_MODE;
            end
            KIND_ZERO: begin
                n_f.status = STATUS_ZERO_DIM;
            end
            KIND_RESIZE, KIND_LETTERBOX, KIND_CROP: begin
                n_f.erase_canvas = 1'b1;
                n_f.draw_overlay = 1'b1;
                n_f.status       = STATUS_OK;
                n_f.src_right    = s.ow;
                n_f.src_bottom   = s.oh;
                n_f.dst_right    = s.cw;
                n_f.dst_bottom   = s.ch;
                if (s.kind == KIND_LETTERBOX) begin
                    if (s.vert) begin
                        n_f.dst_top    = off;
                        n_f.dst_bottom = span_end;
                    end else begin
                        n_f.dst_left   = off;
                        n_f.dst_right  = span_end;
                    end
                end else if (s.kind == KIND_CROP) begin
                    if (s.vert) begin
                        n_f.src_top    = off;
                        n_f.src_bottom = span_end;
                    end else begin
                        n_f.src_left   = off;
                        n_f.src_right  = span_end;
                    end
                end
            end
            default: begin
                n_f = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_f_v <= 1'b0;
        end else begin
            if (w_a_en) begin
                r_a_v <= i_in_valid;
            end
            if (w_b_en) begin
                r_b_v <= r_a_v;
            end
            if (w_f_en) begin
                r_f_v <= w_div_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_en) begin
            r_a <= n_a;
        end
        if (w_b_en) begin
            r_b <= n_b;
        end
        if (w_f_en) begin
            r_f <= n_f;
        end
    end

    assign o_out_valid = r_f_v;
    assign o_out_word  = r_f;

    `OFRC_ASSERT_IMPL(a_draw_implies_ok, o_out_valid && o_out_word.draw_overlay, o_out_word.erase_canvas && (o_out_word.status == STATUS_OK), "draw without erase or with error status")
    `OFRC_ASSERT_IMPL(a_error_clears_all, o_out_valid && (o_out_word.status != STATUS_OK), !o_out_word.erase_canvas && !o_out_word.draw_overlay && (o_out_word.src_right == '0) && (o_out_word.dst_right == '0), "error result carries flags or rectangles")
    `OFRC_ASSERT_IMPL(a_rect_ordered, o_out_valid && o_out_word.draw_overlay, (o_out_word.src_left <= o_out_word.src_right) && (o_out_word.src_top <= o_out_word.src_bottom) && (o_out_word.dst_left <= o_out_word.dst_right) && (o_out_word.dst_top <= o_out_word.dst_bottom), "rectangle edges out of order")
    `OFRC_ASSERT_IMPL(a_stall_only_when_full, o_in_stall, r_a_v && r_b_v && !w_div_take, "input stalled with a free front stage")

endmodule

`default_nettype wire

// ===== bench/tb_overlay_fit_rect_calc.sv =====
`timescale 1ns / 100ps

module tb_overlay_fit_rect_calc;
    import ofrc_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_WORDS   = 100;
    localparam int RANDOM_PHASES = 14;
    localparam logic [ADDR_BITS-1:0] MODE_ADDR  = {REG_MODE, 2'b00};
    localparam logic [ADDR_BITS-1:0] CLEAR_ADDR = {REG_CLEAR, 2'b00};
    localparam t_dim DIM_MAX = {DIM_BITS{1'b1}};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_word             in_word = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_word            out_word;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    t_in_word  pending_words[$];
    t_out_word fit_expected[$];
    t_out_word want;
    t_mode     cfg_mode = MODE_LETTERBOX;
    logic      cfg_clear = 1'b0;
    logic      in_taken = 1'b0;
    logic      idle_enable = 1'b1;
    int        gap_left = 0;
    int        stall_left = 0;
    int        error_count = 0;

    overlay_fit_rect_calc uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Expected rectangles for one word under the current mode and clear request.
    function automatic t_out_word fit_rects(t_in_word w, t_mode mode, logic clr);
        t_out_word r;
        t_prod     ow_ch;
        t_prod     cw_oh;
        t_prod     span;
        t_prod     off;
        r = '0;
        ow_ch = t_prod'(w.overlay_width) * t_prod'(w.canvas_height);
        cw_oh = t_prod'(w.canvas_width) * t_prod'(w.overlay_height);
        if (clr) begin
            r.erase_canvas = 1'b1;
        end else if (!w.overlay_present) begin
            r = '0;
        end else if (mode == MODE_ILLEGAL) begin
            r.status = STATUS_ILLEGAL_MODE;
        end else if (w.canvas_width == 0 || w.canvas_height == 0 ||
                     w.overlay_width == 0 || w.overlay_height == 0) begin
            r.status = STATUS_ZERO_DIM;
        end else begin
            r.erase_canvas = 1'b1;
            r.draw_overlay = 1'b1;
            r.status       = STATUS_OK;
            r.src_right    = w.overlay_width;
            r.src_bottom   = w.overlay_height;
            r.dst_right    = w.canvas_width;
            r.dst_bottom   = w.canvas_height;
            if (mode == MODE_LETTERBOX) begin
                if (ow_ch > cw_oh) begin
                    span = cw_oh / t_prod'(w.overlay_width);
                    off  = (t_prod'(w.canvas_height) - span) >> 1;
                    r.dst_top    = off[DIM_BITS-1:0];
                    r.dst_bottom = off[DIM_BITS-1:0] + span[DIM_BITS-1:0];
                end else begin
                    span = ow_ch / t_prod'(w.overlay_height);
                    off  = (t_prod'(w.canvas_width) - span) >> 1;
                    r.dst_left  = off[DIM_BITS-1:0];
                    r.dst_right = off[DIM_BITS-1:0] + span[DIM_BITS-1:0];
                end
            end else if (mode == MODE_CROP) begin
                if (ow_ch < cw_oh) begin
                    span = ow_ch / t_prod'(w.canvas_width);
                    off  = (t_prod'(w.overlay_height) - span) >> 1;
                    r.src_top    = off[DIM_BITS-1:0];
                    r.src_bottom = off[DIM_BITS-1:0] + span[DIM_BITS-1:0];
                end else begin
                    span = cw_oh / t_prod'(w.canvas_height);
                    off  = (t_prod'(w.overlay_width) - span) >> 1;
                    r.src_left  = off[DIM_BITS-1:0];
                    r.src_right = off[DIM_BITS-1:0] + span[DIM_BITS-1:0];
                end
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned e, int unsigned a);
        if (e != a) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
            error_count++;
        end
    endfunction

    function automatic t_dim rand_dim();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return t_dim'(1);
                    1: return t_dim'(2);
                    2: return DIM_MAX - t_dim'(1);
                    default: return DIM_MAX;
                endcase
            end
            1, 2:    return t_dim'($urandom_range(1, 16));
            3, 4, 5: return t_dim'($urandom_range(1, DIM_MAX));
            default: return t_dim'($urandom_range(1, 600));
        endcase
    endfunction

    task automatic add_word(input t_dim cw, input t_dim ch, input t_dim ow, input t_dim oh,
                            input logic present);
        t_in_word w;
        w.canvas_width    = cw;
        w.canvas_height   = ch;
        w.overlay_width   = ow;
        w.overlay_height  = oh;
        w.overlay_present = present;
        pending_words.push_back(w);
    endtask

    task automatic add_random_words(input int count);
        t_in_word w;
        for (int i = 0; i < count; i++) begin
            w.canvas_width    = rand_dim();
            w.canvas_height   = rand_dim();
            w.overlay_width   = rand_dim();
            w.overlay_height  = rand_dim();
            w.overlay_present = ($urandom_range(0, 9) != 0);
            // Now and then one size is zero.
            if ($urandom_range(0, 19) == 0) begin
                case ($urandom_range(0, 3))
                    0: w.canvas_width   = '0;
                    1: w.canvas_height  = '0;
                    2: w.overlay_width  = '0;
                    default: w.overlay_height = '0;
                endcase
            end
            pending_words.push_back(w);
        end
    endtask

    // Returns once every queued word has gone in and every result has come out.
    task automatic wait_idle();
        while (pending_words.size() != 0 || in_valid || fit_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_BITS-1:0] addr,
                             input logic [DATA_BITS-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Upper data bits are random; the block keeps only the register width.
    task automatic set_config(input t_mode mode, input logic clr);
        write_reg(MODE_ADDR, ($urandom() & ~32'h3) | DATA_BITS'(mode));
        write_reg(CLEAR_ADDR, ($urandom() & ~32'h1) | DATA_BITS'(clr));
        cfg_mode  = mode;
        cfg_clear = clr;
    endtask

    // Sender: a word stays on the bus until it has been taken.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_words.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (idle_enable && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 5);
                    in_valid <= 1'b0;
                end else begin
                    in_word  <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Receiver stall bursts.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (idle_enable && rst_n && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 5);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (fit_expected.size() == 0) begin
                    $display("%0t: result word with none expected, got %h", $time, out_word);
                    error_count++;
                end else begin
                    want = fit_expected.pop_front();
                    check_field("erase_canvas", want.erase_canvas, out_word.erase_canvas);
                    check_field("draw_overlay", want.draw_overlay, out_word.draw_overlay);
                    check_field("status", want.status, out_word.status);
                    check_field("src_left", want.src_left, out_word.src_left);
                    check_field("src_top", want.src_top, out_word.src_top);
                    check_field("src_right", want.src_right, out_word.src_right);
                    check_field("src_bottom", want.src_bottom, out_word.src_bottom);
                    check_field("dst_left", want.dst_left, out_word.dst_left);
                    check_field("dst_top", want.dst_top, out_word.dst_top);
                    check_field("dst_right", want.dst_right, out_word.dst_right);
                    check_field("dst_bottom", want.dst_bottom, out_word.dst_bottom);
                end
            end
            if (in_valid && !in_stall)
                fit_expected.push_back(fit_rects(in_word, cfg_mode, cfg_clear));
            in_taken <= in_valid && !in_stall;
        end else begin
            in_taken <= 1'b0;
        end
    end

    initial begin
        t_mode mode;
        logic  clr;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Letterbox out of reset: wide, tall, equal aspect, extremes, zero size, no overlay.
        add_word(1920, 1080, 640, 240, 1'b1);
        add_word(1920, 1080, 300, 800, 1'b1);
        add_word(1600, 900, 320, 180, 1'b1);
        add_word(DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, 1'b1);
        add_word(DIM_MAX, 1, 1, DIM_MAX, 1'b1);
        add_word(1, DIM_MAX, DIM_MAX, 1, 1'b1);
        add_word(0, 480, 640, 480, 1'b1);
        add_word(800, 600, 640, 480, 1'b0);
        wait_idle();

        set_config(MODE_CROP, 1'b0);
        add_word(1920, 1080, 640, 240, 1'b1);
        add_word(1920, 1080, 300, 800, 1'b1);
        add_word(1600, 900, 320, 180, 1'b1);
        add_word(DIM_MAX, 1, 1, DIM_MAX, 1'b1);
        add_word(1, DIM_MAX, DIM_MAX, 1, 1'b1);
        add_word(640, 480, 640, 0, 1'b1);
        wait_idle();

        set_config(MODE_RESIZE, 1'b0);
        add_word(DIM_MAX, DIM_MAX, 1, 1, 1'b1);
        add_word(640, 0, 320, 240, 1'b1);
        wait_idle();

        set_config(MODE_ILLEGAL, 1'b0);
        add_word(640, 480, 320, 240, 1'b1);
        add_word(0, 0, 0, 0, 1'b1);
        wait_idle();

        // A clear request wins over a missing overlay, an illegal mode and zero sizes.
        set_config(MODE_ILLEGAL, 1'b1);
        add_word(640, 480, 320, 240, 1'b0);
        add_word(0, 480, 320, 240, 1'b1);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 4)
                mode = t_mode'(p);
            else if ($urandom_range(0, 9) == 0)
                mode = MODE_ILLEGAL;
            else
                mode = t_mode'($urandom_range(0, 2));
            clr = (p == 4) || (p > 4 && $urandom_range(0, 7) == 0);
            set_config(mode, clr);
            if (p == RANDOM_PHASES - 1) begin
                idle_enable = 1'b0;
                @(negedge clk);
            end
            if (p == 6) begin
                // The sender holds off until the block has emptied.
                add_random_words(PHASE_WORDS / 2);
                wait_idle();
                add_random_words(PHASE_WORDS / 2);
            end else begin
                add_random_words(PHASE_WORDS);
            end
            wait_idle();
        end

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
